// ===== sv/nfrq_pkg.sv =====
// Package for the nearest-floor request queue: opcodes, status codes, states.
`default_nettype none
package nfrq_pkg;
  localparam int ID_W = 16;
  localparam int WEIGHT_W = 10;
  localparam int STATUS_W = 2;
  localparam int MAX_RESULTS = 16;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_REORDER = 3'd3,
    OP_QUERY   = 3'd4,
    OP_EXTRACT = 3'd5,
    OP_CLEAR   = 3'd6,
    OP_NONE    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_RD,
    S_POP_MV,
    S_SORT_RD,
    S_SORT_CMP,
    S_SORT_PUT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_EX_RD,
    S_EX_CHK,
    S_EX_EMIT,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== sv/nearest_floor_request_queue_core.sv =====
// Nearest-floor request queue: request memory, sequencer and result register.
//
// Requests sit in a memory of CAPACITY entries with a registered read and a separate
// write port, walked entry by entry by a small sequencer around one floor-distance
// compare unit. Pop shifts the remaining entries down; reorder is an insertion sort by
// floor distance. Extract first counts matches, then walks the queue again, raising each
// match as a beat and holding until that beat is taken. The block takes no new beat
// until every result of the current one has been taken. Result beats sit in an output
// register; tlast marks the final result of each request. No clearing pass: unwritten
// entries are never used.
`default_nettype none
module nearest_floor_request_queue_core
  import nfrq_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int FLOOR_BITS = 8
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    s_tvalid,
  output logic                                         s_tready,
  // req_type, in_id, in_from_floor, in_to_floor, in_weight, floor (low first)
  input  wire logic [((3+ID_W+3*FLOOR_BITS+WEIGHT_W+7)/8)*8-1:0] s_tdata,
  output logic                                         m_tvalid,
  input  wire logic                                    m_tready,
  // out_id, out_from_floor, out_to_floor, out_weight, status, occupancy
  output logic [((ID_W+2*FLOOR_BITS+WEIGHT_W+STATUS_W+5+7)/8)*8-1:0] m_tdata,
  output logic                                         m_tlast
);
  localparam int OW   = ((ID_W+2*FLOOR_BITS+WEIGHT_W+STATUS_W+5+7)/8)*8;
  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY+1);
  localparam int EW   = ID_W + 2*FLOOR_BITS + WEIGHT_W;
  localparam int RW   = ID_W + 2*FLOOR_BITS + WEIGHT_W + STATUS_W;

  // input field offsets
  localparam int O_ID = 3;
  localparam int O_FR = O_ID + ID_W;
  localparam int O_TO = O_FR + FLOOR_BITS;
  localparam int O_WT = O_TO + FLOOR_BITS;
  localparam int O_FL = O_WT + WEIGHT_W;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [EW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  state_t state, state_next;
  op_t    op;
  logic [FLOOR_BITS-1:0] fl;
  logic [CW-1:0] count;
  logic [CW-1:0] i, j;       // walk indexes
  logic [CW-1:0] keep;       // extract write pointer
  logic [CW-1:0] limit;      // entries to walk while extracting
  logic [4:0]    nres;       // matches counted, then matches left to hand out
  logic [EW-1:0] key;
  logic [RW-1:0] res;
  logic          res_last;
  logic          res_valid;

  function automatic logic [FLOOR_BITS-1:0] from_of(input logic [EW-1:0] e);
    from_of = e[ID_W +: FLOOR_BITS];
  endfunction

  function automatic logic [FLOOR_BITS-1:0] gap(input logic [FLOOR_BITS-1:0] a,
                                                input logic [FLOOR_BITS-1:0] b);
    gap = (a > b) ? a - b : b - a;
  endfunction

  // shared compare unit
  logic [FLOOR_BITS-1:0] key_gap, rd_gap;
  logic                  gap_gt, floor_eq;
  assign key_gap  = gap(from_of(key), fl);
  assign rd_gap   = gap(from_of(rd_data), fl);
  assign gap_gt   = rd_gap > key_gap;
  assign floor_eq = from_of(rd_data) == fl;

  logic       scan_hit, ex_hit;
  logic [4:0] nres_sum;
  assign scan_hit = floor_eq && nres < 5'(MAX_RESULTS);
  assign nres_sum = nres + 5'(scan_hit);
  assign ex_hit   = floor_eq && nres != '0;

  assign s_tready = (state == S_IDLE) && !res_valid;
  logic acc;
  assign acc = s_tvalid && s_tready;
  logic out_go;
  assign out_go = m_tvalid && m_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (op_t'(s_tdata[2:0]))
            OP_POP, OP_PEEK: state_next = (count == '0) ? S_OUT : S_POP_RD;
            OP_REORDER:      state_next = (count > 1) ? S_SORT_RD : S_OUT;
            OP_QUERY, OP_EXTRACT: state_next = (count == '0) ? S_OUT : S_SCAN_RD;
            default:         state_next = S_OUT;
          endcase
        end
      end
      S_POP_RD:   state_next = S_POP_MV;
      S_POP_MV:   state_next = (op == OP_PEEK || i >= count) ? S_OUT : S_POP_MV;
      S_SORT_RD:  state_next = S_SORT_CMP;
      S_SORT_CMP: state_next = (j != '0 && gap_gt) ? S_SORT_CMP : S_SORT_PUT;
      S_SORT_PUT: state_next = (i + 1'b1 >= count) ? S_OUT : S_SORT_RD;
      S_SCAN_RD:  state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (i + 1'b1 < count) state_next = S_SCAN_RD;
        else if (op == OP_EXTRACT && nres_sum != '0) state_next = S_EX_RD;
        else state_next = S_OUT;
      end
      S_EX_RD:    state_next = S_EX_CHK;
      S_EX_CHK: begin
        if (ex_hit) state_next = S_EX_EMIT;
        else if (i + 1'b1 >= limit) state_next = S_IDLE;
        else state_next = S_EX_RD;
      end
      S_EX_EMIT: begin
        if (out_go) state_next = (i >= limit) ? S_IDLE : S_EX_RD;
      end
      S_OUT:      state_next = (!res_valid) ? S_IDLE : S_OUT;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    rd_addr = i[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = i[AW-1:0];
    wr_data = rd_data;
    case (state)
      S_IDLE: begin
        // reorder starts from entry one, everything else from the head
        rd_addr = (op_t'(s_tdata[2:0]) == OP_REORDER) ? AW'(1) : '0;
        wr_addr = count[AW-1:0];
        wr_data = {s_tdata[O_WT +: WEIGHT_W], s_tdata[O_TO +: FLOOR_BITS],
                   s_tdata[O_FR +: FLOOR_BITS], s_tdata[O_ID +: ID_W]};
        wr_en   = acc && op_t'(s_tdata[2:0]) == OP_PUSH && count < CW'(CAPACITY);
      end
      S_POP_RD:   rd_addr = AW'(1);
      S_POP_MV: begin
        // shift down: write entry i-1 with data read from i
        rd_addr = (i + 1'b1 < count) ? AW'(i + 1'b1) : i[AW-1:0];
        wr_addr = AW'(i - 1'b1);
        wr_en   = op == OP_POP && i < count && i != '0;
      end
      S_SORT_RD:  rd_addr = AW'(i - 1'b1);
      S_SORT_CMP: begin
        rd_addr = AW'(j - 2'd2);
        wr_addr = j[AW-1:0];
        wr_en   = j != '0 && gap_gt;
      end
      S_SORT_PUT: begin
        rd_addr = AW'(i + 1'b1);
        wr_addr = j[AW-1:0];
        wr_data = key;
        wr_en   = 1'b1;
      end
      S_EX_CHK: begin
        wr_addr = keep[AW-1:0];
        wr_en   = !ex_hit;
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      res_valid <= 1'b0;
      res_last <= 1'b0;
    end else begin
      state <= state_next;
      if (out_go) res_valid <= 1'b0;
      case (state)
        S_IDLE: if (acc) begin
          op    <= op_t'(s_tdata[2:0]);
          fl    <= s_tdata[O_FL +: FLOOR_BITS];
          i     <= '0;
          keep  <= '0;
          nres  <= '0;
          res   <= {ST_OK, {EW{1'b0}}};
          case (op_t'(s_tdata[2:0]))
            OP_PUSH:
              if (count < CW'(CAPACITY)) count <= count + 1'b1;
              else res <= {ST_FULL, {EW{1'b0}}};
            OP_POP, OP_PEEK:
              if (count == '0) res <= {ST_EMPTY, {EW{1'b0}}};
            OP_QUERY, OP_EXTRACT:
              if (count == '0) res <= {ST_EMPTY, {EW{1'b0}}};
            OP_CLEAR: count <= '0;
            OP_REORDER: i <= CW'(1);
            default: ;
          endcase
        end
        S_POP_RD: begin
          res <= {ST_OK, rd_data};
          i   <= CW'(1);
        end
        S_POP_MV: begin
          if (op == OP_POP && i >= count) count <= count - 1'b1;
          else i <= i + 1'b1;
        end
        S_SORT_RD: begin
          key <= rd_data;
          j   <= i;
        end
        S_SORT_CMP: begin
          // rd_data holds entry j-1; first cycle it is entry i-1 from S_SORT_RD
          if (j != '0 && gap_gt) j <= j - 1'b1;
        end
        S_SORT_PUT: i <= i + 1'b1;
        S_SCAN_CHK: begin
          nres <= nres_sum;
          if (i + 1'b1 >= count) begin
            i <= '0;
            // extract: settle the final occupancy before the first beat goes out
            if (op == OP_EXTRACT && nres_sum != '0) begin
              limit <= count;
              count <= count - CW'(nres_sum);
            end else begin
              res <= {((nres_sum != '0) ? ST_OK : ST_EMPTY), {EW{1'b0}}};
            end
          end else begin
            i <= i + 1'b1;
          end
        end
        S_EX_CHK: begin
          i <= i + 1'b1;
          if (ex_hit) begin
            res       <= {ST_OK, rd_data};
            res_valid <= 1'b1;
            res_last  <= (nres == 5'd1);
            nres      <= nres - 1'b1;
          end else begin
            keep <= keep + 1'b1;
          end
        end
        S_OUT: if (!res_valid) begin
          res_valid <= 1'b1;
          res_last  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  logic [CW-1:0] occ_out;
  assign occ_out = count;
  assign m_tvalid = res_valid;
  assign m_tlast  = res_last;
  assign m_tdata  = OW'({5'(occ_out), res});
endmodule
`default_nettype wire

// ===== sv/nfrq_checker.sv =====
// Port checker for the nearest-floor request queue, bound to the queue core.
`default_nettype none
module nfrq_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  input wire logic s_tready,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic m_tlast
);
  // hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
  // hold tlast of a stalled result beat
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tlast)) else $error("last changed while stalled");
  // take no request while a result waits
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("ready with result pending");
  // a request accept drops ready
  a_seq: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("ready after accept");
  // no result right after reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result after reset");
endmodule

bind nearest_floor_request_queue_core nfrq_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast)
);
`default_nettype wire

// ===== test/tb_nearest_floor_request_queue_core.sv =====
// Testbench for the nearest-floor request queue core: random stream stimulus and result checking.
`timescale 1ns / 100ps
`default_nettype none
module tb_nearest_floor_request_queue_core;
  import nfrq_pkg::*;

  localparam int CAP = 16;
  localparam int FB = 8;
  localparam int IN_W = ((3 + ID_W + 3 * FB + WEIGHT_W + 7) / 8) * 8;
  localparam int OUT_W = ((ID_W + 2 * FB + WEIGHT_W + STATUS_W + 5 + 7) / 8) * 8;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [FB-1:0]       from_fl;
    logic [FB-1:0]       to_fl;
    logic [WEIGHT_W-1:0] weight;
  } request_t;

  typedef struct {
    request_t req;
    status_t  status;
    logic [4:0] occ;
    logic       last;
  } beat_t;

  class queue_scoreboard;
    request_t held[CAP];
    int       count;
    beat_t    due[$];
    int       errors;
    int       beats_seen;
    int       ops_seen[8];

    function void clear_state();
      count = 0;
      errors = 0;
      beats_seen = 0;
      due.delete();
      foreach (ops_seen[k]) ops_seen[k] = 0;
    endfunction

    function int unsigned gap(logic [FB-1:0] a, logic [FB-1:0] b);
      return (a > b) ? a - b : b - a;
    endfunction

    // Work out the result beats of one accepted request.
    function void note_request(op_t op, request_t r, logic [FB-1:0] fl);
      beat_t    res[$];
      beat_t    b;
      request_t key;
      int       j;
      int       keep;
      bit       hit;
      ops_seen[op]++;
      b.req = '0;
      b.status = ST_OK;
      case (op)
        OP_PUSH: begin
          if (count >= CAP) begin
            b.status = ST_FULL;
          end else begin
            held[count] = r;
            count++;
          end
          res.push_back(b);
        end
        OP_POP, OP_PEEK: begin
          if (count == 0) begin
            b.status = ST_EMPTY;
          end else begin
            b.req = held[0];
            if (op == OP_POP) begin
              for (int k = 0; k < count - 1; k++) held[k] = held[k+1];
              count--;
            end
          end
          res.push_back(b);
        end
        OP_REORDER: begin
          for (int k = 1; k < count; k++) begin
            key = held[k];
            j = k;
            while (j > 0 && gap(held[j-1].from_fl, fl) > gap(key.from_fl, fl)) begin
              held[j] = held[j-1];
              j--;
            end
            held[j] = key;
          end
          res.push_back(b);
        end
        OP_QUERY: begin
          hit = 0;
          for (int k = 0; k < count; k++) if (held[k].from_fl == fl) hit = 1;
          b.status = hit ? ST_OK : ST_EMPTY;
          res.push_back(b);
        end
        OP_EXTRACT: begin
          keep = 0;
          for (int k = 0; k < count; k++) begin
            if (held[k].from_fl == fl && res.size() < MAX_RESULTS) begin
              b.req = held[k];
              res.push_back(b);
            end else begin
              held[keep] = held[k];
              keep++;
            end
          end
          count = keep;
          if (res.size() == 0) begin
            b.req = '0;
            b.status = ST_EMPTY;
            res.push_back(b);
          end
        end
        OP_CLEAR: begin
          count = 0;
          res.push_back(b);
        end
        default: res.push_back(b);
      endcase
      foreach (res[k]) begin
        res[k].occ = count[4:0];
        res[k].last = (k == res.size() - 1);
        due.push_back(res[k]);
      end
    endfunction

    function void check_beat(logic [OUT_W-1:0] d, logic lst);
      beat_t e;
      beats_seen++;
      if (due.size() == 0) begin
        $display("%0t: unexpected result beat %h last %b", $time, d, lst);
        errors++;
        return;
      end
      e = due.pop_front();
      if (d[15:0] !== e.req.id || d[23:16] !== e.req.from_fl || d[31:24] !== e.req.to_fl
          || d[41:32] !== e.req.weight || d[43:42] !== e.status || d[48:44] !== e.occ
          || d[OUT_W-1:49] !== '0 || lst !== e.last) begin
        $display("%0t: mismatch expected id %h from %h to %h wt %h st %0d occ %0d last %b",
                 $time, e.req.id, e.req.from_fl, e.req.to_fl, e.req.weight, e.status,
                 e.occ, e.last);
        $display("%0t:          actual id %h from %h to %h wt %h st %0d occ %0d last %b",
                 $time, d[15:0], d[23:16], d[31:24], d[41:32], d[43:42], d[48:44], lst);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 0;
  logic             rst = 1;
  logic             s_tvalid = 0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;
  bit               calm = 0;
  queue_scoreboard  board;

  always #4 clk = ~clk;

  nearest_floor_request_queue_core #(.CAPACITY(CAP), .FLOOR_BITS(FB)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_beat(m_tdata, m_tlast);
  end

  // Stall the result side in random bursts.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 17);
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  task automatic send(op_t op, logic [ID_W-1:0] id, logic [FB-1:0] src, logic [FB-1:0] dst,
                      logic [WEIGHT_W-1:0] wt, logic [FB-1:0] fl);
    request_t r;
    int       gap_len;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap_len = $urandom_range(1, 17);
      s_tvalid <= 1'b0;
      repeat (gap_len) @(posedge clk);
    end
    r = '{id, src, dst, wt};
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'({fl, wt, dst, src, id, op});
    do @(posedge clk); while (!s_tready);
    board.note_request(op, r, fl);
  endtask

  task automatic push_rand(logic [FB-1:0] src);
    send(OP_PUSH, ID_W'($urandom), src, FB'($urandom), WEIGHT_W'($urandom), FB'($urandom));
  endtask

  // Pick a floor that is often one in use, so queries and extracts find matches.
  function automatic logic [FB-1:0] pick_floor();
    if ($urandom_range(0, 3) == 0) return FB'($urandom);
    return FB'($urandom_range(0, 3));
  endfunction

  initial begin
    int   left;
    op_t  op;
    board = new();
    board.clear_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty queue cases, then fill past capacity with extreme fields.
    send(OP_POP, 0, 0, 0, 0, 0);
    send(OP_PEEK, 0, 0, 0, 0, 0);
    send(OP_EXTRACT, 0, 0, 0, 0, 8'd5);
    send(OP_QUERY, 0, 0, 0, 0, 8'd5);
    send(OP_REORDER, 0, 0, 0, 0, 8'd255);
    send(OP_NONE, 16'hFFFF, 8'hFF, 8'hFF, 10'h3FF, 8'hFF);
    send(OP_PUSH, 16'hFFFF, 8'hFF, 8'hFF, 10'h3FF, 8'hFF);
    send(OP_PUSH, 16'h0000, 8'h00, 8'h00, 10'h000, 8'h00);
    for (int k = 0; k < 15; k++) push_rand(k % 3 == 0 ? 8'd7 : 8'($urandom));
    send(OP_QUERY, 0, 0, 0, 0, 8'd7);
    send(OP_PEEK, 0, 0, 0, 0, 0);
    send(OP_REORDER, 0, 0, 0, 0, 8'd128);
    send(OP_EXTRACT, 0, 0, 0, 0, 8'd7);
    send(OP_POP, 0, 0, 0, 0, 0);
    send(OP_CLEAR, 0, 0, 0, 0, 0);

    // Random part: pushes on a few floors for nearly half the requests, mixed with every other operation.
    for (int n = 0; n < 350; n++) begin
      if (n > 300) calm = 1;
      if ($urandom_range(0, 99) < 45) begin
        op = OP_PUSH;
      end else begin
        op = op_t'($urandom_range(1, 7));
        if (op == OP_CLEAR && $urandom_range(0, 3) != 0) op = OP_EXTRACT;
      end
      if (op == OP_PUSH) push_rand(pick_floor());
      else send(op, ID_W'($urandom), FB'($urandom), FB'($urandom), WEIGHT_W'($urandom),
                pick_floor());
    end
    s_tvalid <= 1'b0;

    left = 20000;
    while (board.due.size() != 0 && left > 0) begin
      @(posedge clk);
      left--;
    end
    repeat (500) @(posedge clk);
    if (board.due.size() != 0) board.errors++;
    $display("Covered %0d pushes, %0d pops, %0d peeks, %0d reorders, %0d queries,",
             board.ops_seen[OP_PUSH], board.ops_seen[OP_POP], board.ops_seen[OP_PEEK],
             board.ops_seen[OP_REORDER], board.ops_seen[OP_QUERY]);
    $display("%0d extracts, %0d clears, %0d unused ops; %0d result beats checked.",
             board.ops_seen[OP_EXTRACT], board.ops_seen[OP_CLEAR], board.ops_seen[OP_NONE],
             board.beats_seen);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
